[rtl/core/matrix4x4_multiply_core_macros.svh]
// Assertion macros shared by the 4x4 matrix multiply core.
// Depends on nothing; included by the files that carry assertions.
`ifndef MATRIX4X4_MULTIPLY_CORE_MACROS_SVH
`define MATRIX4X4_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MM4_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mm4 same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define MM4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mm4 next-cycle check failed");

`endif

[rtl/core/mm4_pkg.sv]
// Shared types and constants for the 4x4 matrix multiply core.
// Depends on nothing; used by the channel interfaces, the MAC unit and the top level.
package mm4_pkg;

   localparam int WORD_W = 32;
   localparam int POS_W  = 4;
   localparam int CMD_W  = 2;
   localparam int PROD_W = 2 * WORD_W;
   // Four full products summed exactly need two guard bits.
   localparam int ACC_W  = PROD_W + 2;

   localparam logic [CMD_W-1:0] CMD_WRITE_LEFT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_RIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

   localparam logic [POS_W-1:0] LAST_POS = 4'd15;

   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   typedef struct packed {
      logic issue;   // operands are valid for a multiply this cycle
      logic first;   // this product opens a new dot product
   } mac_ctl_type;

endpackage

[rtl/core/mm4_channels.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on mm4_pkg for field widths.
interface mm4_req_if;
   logic                              valid;
   logic                              ready;
   logic [mm4_pkg::CMD_W-1:0]         command;
   logic [mm4_pkg::POS_W-1:0]         position;
   logic signed [mm4_pkg::WORD_W-1:0] element;

   modport source (output valid, command, position, element, input ready);
   modport sink   (input valid, command, position, element, output ready);
endinterface

interface mm4_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mm4_pkg::POS_W-1:0]         position_res;
   logic signed [mm4_pkg::WORD_W-1:0] element_res;
   logic                              saturated;
   logic                              last;

   modport source (output valid, position_res, element_res, saturated, last, input ready);
   modport sink   (input valid, position_res, element_res, saturated, last, output ready);
endinterface

[rtl/core/mm4_mac.sv]
// Shared multiply-accumulate unit: one registered 32x32 multiplier, an exact
// accumulator, and the fixed-point rescale with saturation. Depends on mm4_pkg.
module mm4_mac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mm4_pkg::mac_ctl_type              ctl,
   input  logic signed [mm4_pkg::WORD_W-1:0] mul_a,
   input  logic signed [mm4_pkg::WORD_W-1:0] mul_b,
   output logic [mm4_pkg::WORD_W-1:0]        res_word,
   output logic                              res_sat
);

   localparam int ACC_W  = mm4_pkg::ACC_W;
   localparam int PROD_W = mm4_pkg::PROD_W;
   localparam int WORD_W = mm4_pkg::WORD_W;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff, prod_vld_in;
   logic                     prod_first_ff, prod_first_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W-1:0]  shifted;
   logic                     fits;

   assign prod_in       = mul_a * mul_b;
   assign prod_vld_in   = ctl.issue;
   assign prod_first_in = ctl.first;

   assign acc_base = prod_first_ff ? '0 : acc_ff;
   assign acc_in   = prod_vld_ff ? acc_base + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff}
                                 : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      prod_first_ff <= prod_first_in;
      acc_ff        <= acc_in;
   end

   // Arithmetic shift rounds toward minus infinity; the result fits when all
   // bits from the word's sign bit upwards agree.
   assign shifted = acc_ff >>> FRAC_BITS;
   assign fits    = (&shifted[ACC_W-1:WORD_W-1]) | ~(|shifted[ACC_W-1:WORD_W-1]);

   assign res_sat  = ~fits;
   assign res_word = fits ? shifted[WORD_W-1:0]
                          : (shifted[ACC_W-1] ? mm4_pkg::WORD_MIN : mm4_pkg::WORD_MAX);

endmodule

[rtl/core/matrix4x4_multiply_core.sv]
// Top level of the 4x4 signed fixed-point matrix multiply core.
// Depends on mm4_pkg, mm4_channels.sv, mm4_mac.sv and the assertion macro header.
//
//  Channel   Direction  Carries                                       Transaction
//  req_port  in         command, position, element                    valid & ready
//  rsp_port  out        position_res, element_res, saturated, last    valid & ready
//
// A write transaction (left or right element) leaves the sequencer idle, so the
// core is ready again in the next cycle. A compute transaction works through
// the 16 product elements in turn: the one shared multiplier takes the four
// terms of each element in the multiply step, the drain step settles the
// accumulator and the emit step loads the result register. A stalled response
// holds the sequencer in its emit step. Synchronous reset clears both matrix
// stores to zero and empties the response register.
module matrix4x4_multiply_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   mm4_req_if.sink      req_port,
   mm4_rsp_if.source    rsp_port
);

   `include "matrix4x4_multiply_core_macros.svh"

   localparam int WORD_W = mm4_pkg::WORD_W;
   localparam int POS_W  = mm4_pkg::POS_W;
   localparam int DEPTH  = 1 << POS_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MULT  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [POS_W-1:0]  elem_ff, elem_in;   // product element being worked on
   logic [1:0]        k_ff, k_in;         // term of the dot product

   // The two operand stores, cleared by reset so unloaded entries read as zero.
   logic [WORD_W-1:0] left_ff  [DEPTH];
   logic [WORD_W-1:0] right_ff [DEPTH];

   logic              req_take;
   logic              out_free;
   logic              out_load;

   logic              out_vld_ff, out_vld_in;
   logic [POS_W-1:0]  out_pos_ff;
   logic [WORD_W-1:0] out_elem_ff;
   logic              out_sat_ff;
   logic              out_last_ff;

   mm4_pkg::mac_ctl_type mac_ctl;
   logic [WORD_W-1:0]    mac_word;
   logic                 mac_sat;
   logic [POS_W-1:0]     left_idx;
   logic [POS_W-1:0]     right_idx;

   // Requests are only taken while the sequencer is idle; the response
   // register is separate, so loads may go on while a result still waits.
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid & req_port.ready;

   // Column-major indexing: element (col,row) at col*4+row. For product
   // element elem, row is its low two bits and column its high two bits.
   assign left_idx  = {k_ff, elem_ff[1:0]};
   assign right_idx = {elem_ff[3:2], k_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
         end
      end else if (req_take) begin
         if (req_port.command == mm4_pkg::CMD_WRITE_LEFT) begin
            left_ff[req_port.position] <= req_port.element;
         end
         if (req_port.command == mm4_pkg::CMD_WRITE_RIGHT) begin
            right_ff[req_port.position] <= req_port.element;
         end
      end
   end

   assign mac_ctl.issue = (state_ff == ST_MULT);
   assign mac_ctl.first = (k_ff == 2'd0);

   mm4_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .mul_a    (left_ff[left_idx]),
      .mul_b    (right_ff[right_idx]),
      .res_word (mac_word),
      .res_sat  (mac_sat)
   );

   // The response register can take a new result when it is empty or its
   // current transaction completes in this cycle.
   assign out_free = ~out_vld_ff | rsp_port.ready;
   assign out_load = (state_ff == ST_EMIT) & out_free;

   always_comb begin
      state_in = state_ff;
      elem_in  = elem_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_port.command == mm4_pkg::CMD_COMPUTE) begin
               state_in = ST_MULT;
               elem_in  = '0;
               k_in     = '0;
            end
         end
         ST_MULT: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last product is being folded into the accumulator.
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               elem_in  = elem_ff + 1'b1;
               state_in = (elem_ff == mm4_pkg::LAST_POS) ? ST_IDLE : ST_MULT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_vld_in = out_load | (out_vld_ff & ~rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         elem_ff    <= '0;
         k_ff       <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         elem_ff    <= elem_in;
         k_ff       <= k_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pos_ff  <= elem_ff;
         out_elem_ff <= mac_word;
         out_sat_ff  <= mac_sat;
         out_last_ff <= (elem_ff == mm4_pkg::LAST_POS);
      end
   end

   assign rsp_port.valid        = out_vld_ff;
   assign rsp_port.position_res = out_pos_ff;
   assign rsp_port.element_res  = out_elem_ff;
   assign rsp_port.saturated    = out_sat_ff;
   assign rsp_port.last         = out_last_ff;

   // A compute transaction starts the first dot product at its first term.
   `MM4_ASSERT_NEXT(a_compute_starts, clock, reset, req_take && req_port.command == mm4_pkg::CMD_COMPUTE, state_ff == ST_MULT && k_ff == 2'd0 && elem_ff == '0)
   // A result waiting on a stalled response must not advance the sequencer.
   `MM4_ASSERT_NEXT(a_emit_holds, clock, reset, state_ff == ST_EMIT && out_vld_ff && !rsp_port.ready, state_ff == ST_EMIT && $stable(elem_ff))
   // The final flag goes only with the last product element.
   `MM4_ASSERT_IMPLY(a_last_pos, clock, reset, out_vld_ff && out_last_ff, out_pos_ff == mm4_pkg::LAST_POS)

endmodule
